### rtl/core/hs1e_pkg.sv
// hs1e_pkg: types, codes and constants for the hmac-sha1 engine
// used by hs1e_core and hmac_sha1_engine; no dependencies
package hs1e_pkg;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data_byte;
  } hs1e_in_t;

  typedef struct packed {
    logic [31:0] mac_word;
    logic [2:0]  word_index;
    logic        last_word;
  } hs1e_out_t;

  localparam logic [1:0] OP_KEY = 2'd0;
  localparam logic [1:0] OP_MSG = 2'd1;
  localparam logic [1:0] OP_FIN = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_KRD, ST_KFD, ST_PEND, ST_PAD80, ST_PADZ, ST_PADL,
    ST_PWAIT, ST_KWR, ST_DFD, ST_OUT
  } hs1e_state_t;

  typedef enum logic [1:0] {KM_RAW, KM_IPAD, KM_OPAD} hs1e_kmode_t;
  typedef enum logic [1:0] {PM_LKEY, PM_INNER, PM_OUTER} hs1e_pmode_t;
  typedef enum logic [1:0] {JOB_KEY, JOB_MSG, JOB_FIN} hs1e_job_t;

  typedef struct packed {
    logic init;
    logic start;
  } hs1e_ctl_t;

  localparam logic [159:0] SHA1_IV = {32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                      32'h10325476, 32'hC3D2E1F0};
  localparam logic [7:0] IPAD_BYTE = 8'h36;
  localparam logic [7:0] OPAD_BYTE = 8'h5c;
  localparam logic [7:0] PAD_BYTE  = 8'h80;

  function automatic logic [31:0] sha1_k(input logic [6:0] rnd);
    logic [31:0] k;
    priority if (rnd < 7'd20) k = 32'h5A827999;
    else if (rnd < 7'd40)     k = 32'h6ED9EBA1;
    else if (rnd < 7'd60)     k = 32'h8F1BBCDC;
    else                      k = 32'hCA62C1D6;
    return k;
  endfunction

endpackage

### rtl/core/hs1e_core.sv
// hs1e_core: sha-1 compression, one round per cycle over a 16-word window
// depends on hs1e_pkg
module hs1e_core import hs1e_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  hs1e_ctl_t    ctl,
  input  logic [511:0] blk,
  output logic         busy,
  output logic [159:0] chain
);

  logic [159:0] chain_r;
  logic         busy_r;
  logic [6:0]   rnd_r;
  logic [31:0]  a_r, b_r, c_r, d_r, e_r;
  logic [31:0]  w_r [16];
  logic [31:0]  wx, cur, f, t;

  always_comb begin
    wx  = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
    cur = (rnd_r < 7'd16) ? w_r[0] : {wx[30:0], wx[31]};
    priority if (rnd_r < 7'd20) f = (b_r & c_r) | (~b_r & d_r);
    else if (rnd_r < 7'd40)     f = b_r ^ c_r ^ d_r;
    else if (rnd_r < 7'd60)     f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
    else                        f = b_r ^ c_r ^ d_r;
    t = {a_r[26:0], a_r[31:27]} + f + e_r + sha1_k(rnd_r) + cur;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      rnd_r   <= '0;
      chain_r <= SHA1_IV;
    end else begin
      if (ctl.init) chain_r <= SHA1_IV;
      if (ctl.start) begin
        busy_r <= 1'b1;
        rnd_r  <= '0;
      end else if (busy_r) begin
        rnd_r <= rnd_r + 7'd1;
        if (rnd_r == 7'd79) begin
          busy_r  <= 1'b0;
          chain_r <= {chain_r[159:128] + t, chain_r[127:96] + a_r,
                      chain_r[95:64] + {b_r[1:0], b_r[31:2]},
                      chain_r[63:32] + c_r, chain_r[31:0] + d_r};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      for (int k = 0; k < 16; k++) w_r[k] <= blk[511 - 32*k -: 32];
      {a_r, b_r, c_r, d_r, e_r} <= chain_r;
    end else if (busy_r) begin
      for (int k = 0; k < 15; k++) w_r[k] <= w_r[k+1];
      w_r[15] <= cur;
      a_r <= t;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  assign busy  = busy_r;
  assign chain = chain_r;

endmodule

### rtl/core/hmac_sha1_engine.sv
// hmac_sha1_engine: streaming hmac-sha1 top level, byte sequencer and key store
// depends on hs1e_pkg and hs1e_core
//
//   channel | ports                         | word
//   input   | in_valid in_ready in_data     | hs1e_in_t  (op, data_byte)
//   result  | out_valid out_ready out_data  | hs1e_out_t (mac_word, word_index, last_word)
//
// key byte: stored in the key store; the 65th key byte runs a raw key pass, later ones are hashed
// message byte: fed through the pending register, held while the block buffer waits for the core
// the key store has a registered read, so each key-pad pass alternates a read and a
// feed state per key byte; finish from the message phase pads the inner hash, runs
// the outer key pad and digest pass, plus a key pass first when it closes the key
// synchronous active-low reset, no clearing pass; in_ready only in idle,
// and five result words are held until taken
module hmac_sha1_engine import hs1e_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  hs1e_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output hs1e_out_t out_data
);

  hs1e_state_t  st_r, st_nxt;
  hs1e_job_t    job_r;
  hs1e_kmode_t  kmode_r;
  hs1e_pmode_t  pmode_r;
  logic         phase_r, long_r;
  logic [6:0]   klen_r, cidx_r, fill_r;
  logic [60:0]  cnt_r;
  logic [63:0]  len_r;
  logic [511:0] blk_r;
  logic [159:0] dig_r;
  logic [7:0]   pend_r, kq_r;
  logic         kvq_r;
  logic [63:0]  kv_r;
  logic [7:0]   kmem [64];

  hs1e_ctl_t    ctl;
  logic         busy;
  logic [159:0] chain;
  logic         acc, close, feed_ok, feed, pw_done, kwe;
  logic [7:0]   fb, kmask, kwd;
  logic [5:0]   kwa;

  hs1e_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .blk   (blk_r),
    .busy  (busy),
    .chain (chain)
  );

  always_comb begin
    acc     = in_valid && in_ready;
    close   = acc && !phase_r && (in_data.op == OP_MSG || in_data.op == OP_FIN);
    feed_ok = fill_r != 7'd64;
    pw_done = (st_r == ST_PWAIT) && (fill_r == 7'd0) && !busy;
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (acc) begin
          priority if (in_data.op == OP_KEY && !phase_r) begin
            if (long_r) st_nxt = ST_PEND;
            else if (klen_r[6]) st_nxt = ST_KRD;
          end else if (close) begin
            st_nxt = long_r ? ST_PAD80 : ST_KRD;
          end else if (in_data.op == OP_MSG) begin
            st_nxt = ST_PEND;
          end else if (in_data.op == OP_FIN) begin
            st_nxt = ST_PAD80;
          end else begin
            st_nxt = ST_IDLE;
          end
        end
      end
      ST_KRD: st_nxt = ST_KFD;
      ST_KFD: begin
        if (feed) begin
          if (cidx_r == 7'd63) begin
            unique case (kmode_r)
              KM_RAW:  st_nxt = ST_PEND;
              KM_IPAD: st_nxt = (job_r == JOB_MSG) ? ST_PEND : ST_PAD80;
              default: st_nxt = ST_DFD;
            endcase
          end else begin
            st_nxt = ST_KRD;
          end
        end
      end
      ST_PEND:  if (feed) st_nxt = ST_IDLE;
      ST_PAD80: if (feed) st_nxt = ST_PADZ;
      ST_PADZ:  if (fill_r == 7'd56) st_nxt = ST_PADL;
      ST_PADL:  if (feed && cidx_r == 7'd7) st_nxt = ST_PWAIT;
      ST_PWAIT: begin
        if (pw_done) begin
          unique case (pmode_r)
            PM_LKEY:  st_nxt = ST_KWR;
            PM_INNER: st_nxt = ST_KRD;
            default:  st_nxt = ST_OUT;
          endcase
        end
      end
      ST_KWR:  if (cidx_r == 7'd19) st_nxt = ST_KRD;
      ST_DFD:  if (feed && cidx_r == 7'd19) st_nxt = ST_PAD80;
      ST_OUT:  if (out_ready && cidx_r == 7'd4) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // outputs and strobes
  always_comb begin
    unique case (kmode_r)
      KM_IPAD: kmask = IPAD_BYTE;
      KM_OPAD: kmask = OPAD_BYTE;
      default: kmask = 8'h00;
    endcase
    feed = 1'b0;
    fb   = 8'h00;
    unique case (st_r)
      ST_KFD: begin
        feed = feed_ok;
        fb   = (kvq_r ? kq_r : 8'h00) ^ kmask;
      end
      ST_PEND: begin
        feed = feed_ok;
        fb   = pend_r;
      end
      ST_PAD80: begin
        feed = feed_ok;
        fb   = PAD_BYTE;
      end
      ST_PADZ: feed = feed_ok && (fill_r != 7'd56);
      ST_PADL: begin
        feed = feed_ok;
        fb   = len_r[63:56];
      end
      ST_DFD: begin
        feed = feed_ok;
        fb   = dig_r[159:152];
      end
      default: feed = 1'b0;
    endcase
    ctl.start = (fill_r == 7'd64) && !busy;
    ctl.init  = (acc && in_data.op == OP_KEY && !phase_r && !long_r && klen_r[6]) ||
                (close && !long_r) || (pw_done && pmode_r == PM_INNER) ||
                (st_r == ST_KWR && cidx_r == 7'd19);
    kwe = (acc && in_data.op == OP_KEY && !phase_r && !long_r && !klen_r[6]) ||
          (st_r == ST_KWR);
    kwa = (st_r == ST_KWR) ? cidx_r[5:0] : klen_r[5:0];
    kwd = (st_r == ST_KWR) ? dig_r[159:152] : in_data.data_byte;
    in_ready  = st_r == ST_IDLE;
    out_valid = st_r == ST_OUT;
    out_data.mac_word   = dig_r[159:128];
    out_data.word_index = cidx_r[2:0];
    out_data.last_word  = cidx_r == 7'd4;
  end

  always_ff @(posedge clk) begin
    if (kwe) kmem[kwa] <= kwd;
    kq_r  <= kmem[cidx_r[5:0]];
    kvq_r <= kv_r[cidx_r[5:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      job_r   <= JOB_KEY;
      kmode_r <= KM_RAW;
      pmode_r <= PM_LKEY;
      phase_r <= 1'b0;
      long_r  <= 1'b0;
      klen_r  <= '0;
      cidx_r  <= '0;
      fill_r  <= '0;
      cnt_r   <= '0;
      kv_r    <= '0;
    end else begin
      st_r <= st_nxt;
      if (kwe) kv_r[kwa] <= 1'b1;
      if (ctl.init) begin
        fill_r <= '0;
        cnt_r  <= '0;
      end else if (ctl.start) begin
        fill_r <= '0;
      end else if (feed) begin
        fill_r <= fill_r + 7'd1;
        cnt_r  <= cnt_r + 61'd1;
      end
      unique case (st_r)
        ST_IDLE: begin
          if (acc) begin
            cidx_r <= '0;
            unique case (in_data.op)
              OP_KEY:  job_r <= JOB_KEY;
              OP_MSG:  job_r <= JOB_MSG;
              default: job_r <= JOB_FIN;
            endcase
            if (in_data.op == OP_KEY && !phase_r && !long_r) begin
              if (klen_r[6]) kmode_r <= KM_RAW;
              else klen_r <= klen_r + 7'd1;
            end
            if (close) begin
              if (long_r) pmode_r <= PM_LKEY;
              else kmode_r <= KM_IPAD;
            end else if (in_data.op == OP_FIN) begin
              pmode_r <= PM_INNER;
            end
          end
        end
        ST_KFD: begin
          if (feed) begin
            cidx_r <= (cidx_r == 7'd63) ? 7'd0 : cidx_r + 7'd1;
            if (cidx_r == 7'd63 && kmode_r == KM_IPAD) begin
              phase_r <= 1'b1;
              pmode_r <= PM_INNER;
            end
          end
        end
        ST_PEND: if (feed && job_r == JOB_KEY) long_r <= 1'b1;
        ST_PADZ: cidx_r <= '0;
        ST_PADL: if (feed) cidx_r <= cidx_r + 7'd1;
        ST_PWAIT: begin
          if (pw_done) begin
            cidx_r <= '0;
            if (pmode_r == PM_LKEY) kv_r <= '0;
            if (pmode_r == PM_INNER) kmode_r <= KM_OPAD;
          end
        end
        ST_KWR: begin
          cidx_r <= cidx_r + 7'd1;
          if (cidx_r == 7'd19) begin
            long_r  <= 1'b0;
            kmode_r <= KM_IPAD;
            cidx_r  <= '0;
          end
        end
        ST_DFD: begin
          if (feed) begin
            cidx_r <= cidx_r + 7'd1;
            if (cidx_r == 7'd19) pmode_r <= PM_OUTER;
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            cidx_r <= cidx_r + 7'd1;
            if (cidx_r == 7'd4) begin
              cidx_r  <= '0;
              phase_r <= 1'b0;
              long_r  <= 1'b0;
              klen_r  <= '0;
              kv_r    <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath words
  always_ff @(posedge clk) begin
    if (acc) pend_r <= in_data.data_byte;
    if (feed) blk_r <= {blk_r[503:0], fb};
    if (st_r == ST_PAD80 && feed) len_r <= {cnt_r, 3'b000};
    else if (st_r == ST_PADL && feed) len_r <= {len_r[55:0], 8'h00};
    if (pw_done) dig_r <= chain;
    else if (st_r == ST_KWR || (st_r == ST_DFD && feed)) dig_r <= {dig_r[151:0], 8'h00};
    else if (st_r == ST_OUT && out_ready) dig_r <= {dig_r[127:0], 32'h0};
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n) fill_r <= 7'd64)
    else $error("block fill past 64");
  a_out_core_idle: assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !busy)
    else $error("mac shown while core busy");
  a_phase_long: assert property (@(posedge clk) disable iff (!rst_n) phase_r |-> !long_r)
    else $error("long key still open in message phase");
  a_clear_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.last_word |=> klen_r == 7'd0 && !phase_r && kv_r == '0)
    else $error("key store not cleared after finish");
`endif

endmodule

### tb/sv/tb_hmac_sha1_engine.sv
// tb_hmac_sha1_engine: self-checking testbench for the streaming hmac-sha1 engine
// directed table plus random key/message sequences, checked by a byte-level sha-1 predictor
// depends on hs1e_pkg and hmac_sha1_engine
module tb_hmac_sha1_engine;
  import hs1e_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam logic [60:0] COUNT_ONE = 61'd1;

  typedef struct {
    hs1e_in_t    word;
    bit          known;
    logic [159:0] mac;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  hs1e_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  hs1e_out_t out_data;

  hs1e_out_t mac_q[$];
  int        errors;
  int        sent_items;
  bit        stim_done;

  // predictor state
  logic [7:0]  blk_bytes[64];
  logic [7:0]  key_bytes[64];
  logic [31:0] hval[5];
  logic [60:0] nbytes;
  int          fill;
  bit          msg_phase;
  bit          long_key;

  dir_row_t dir_rows[13] = '{
    '{'{OP_FIN, 8'h00}, 1'b1, 160'hfbdb1d1b18aa6c08324b7d64b71fb76370690e1d},
    '{'{OP_KEY, 8'h00}, 1'b0, 160'h0},
    '{'{OP_KEY, 8'hff}, 1'b0, 160'h0},
    '{'{OP_NONE, 8'ha5}, 1'b0, 160'h0},
    '{'{OP_MSG, 8'hff}, 1'b0, 160'h0},
    '{'{OP_MSG, 8'h00}, 1'b0, 160'h0},
    '{'{OP_KEY, 8'h5a}, 1'b0, 160'h0},
    '{'{OP_NONE, 8'h3c}, 1'b0, 160'h0},
    '{'{OP_FIN, 8'hff}, 1'b0, 160'h0},
    '{'{OP_MSG, 8'h80}, 1'b0, 160'h0},
    '{'{OP_FIN, 8'h00}, 1'b0, 160'h0},
    '{'{OP_KEY, 8'h01}, 1'b0, 160'h0},
    '{'{OP_FIN, 8'h7f}, 1'b0, 160'h0}
  };

  hmac_sha1_engine u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic logic [31:0] rotl(input logic [31:0] x, input int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic void sha_compress();
    logic [31:0] w[16];
    logic [31:0] a, b, c, d, e, f, k, t, x;
    for (int i = 0; i < 16; i++) begin
      w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    end
    a = hval[0]; b = hval[1]; c = hval[2]; d = hval[3]; e = hval[4];
    for (int i = 0; i < 80; i++) begin
      if (i >= 16) begin
        x = w[(i-3)&15] ^ w[(i-8)&15] ^ w[(i-14)&15] ^ w[i&15];
        w[i&15] = rotl(x, 1);
      end
      if (i < 20) begin
        f = (b & c) | (~b & d); k = 32'h5A827999;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = 32'h6ED9EBA1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d; k = 32'hCA62C1D6;
      end
      t = rotl(a, 5) + f + e + k + w[i&15];
      e = d; d = c; c = rotl(b, 30); b = a; a = t;
    end
    hval[0] += a; hval[1] += b; hval[2] += c; hval[3] += d; hval[4] += e;
  endfunction

  function automatic void sha_start();
    hval = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0};
    nbytes = '0;
    fill = 0;
  endfunction

  function automatic void sha_absorb(input logic [7:0] v);
    blk_bytes[fill] = v;
    fill++;
    nbytes = nbytes + COUNT_ONE;
    if (fill == 64) begin
      sha_compress();
      fill = 0;
    end
  endfunction

  function automatic logic [159:0] sha_final();
    logic [63:0] bits;
    bits = {nbytes, 3'b000};
    sha_absorb(PAD_BYTE);
    while (fill != 56) sha_absorb(8'h00);
    for (int i = 0; i < 8; i++) sha_absorb(bits[63-8*i -: 8]);
    return {hval[0], hval[1], hval[2], hval[3], hval[4]};
  endfunction

  function automatic void hmac_reset();
    foreach (key_bytes[i]) key_bytes[i] = 8'h00;
    sha_start();
    msg_phase = 1'b0;
    long_key = 1'b0;
  endfunction

  function automatic void close_key();
    logic [159:0] dg;
    if (long_key) begin
      dg = sha_final();
      foreach (key_bytes[i]) key_bytes[i] = 8'h00;
      for (int i = 0; i < 20; i++) key_bytes[i] = dg[159-8*i -: 8];
      long_key = 1'b0;
    end
    sha_start();
    for (int i = 0; i < 64; i++) sha_absorb(key_bytes[i] ^ IPAD_BYTE);
    msg_phase = 1'b1;
  endfunction

  // returns 1 when the word completes a mac
  function automatic bit hmac_step(input hs1e_in_t w, output logic [159:0] mac);
    logic [159:0] inner;
    mac = '0;
    case (w.op)
      OP_KEY: begin
        if (!msg_phase) begin
          if (long_key) begin
            sha_absorb(w.data_byte);
          end else if (nbytes < 61'd64) begin
            key_bytes[nbytes[5:0]] = w.data_byte;
            nbytes = nbytes + COUNT_ONE;
          end else begin
            sha_start();
            for (int i = 0; i < 64; i++) sha_absorb(key_bytes[i]);
            sha_absorb(w.data_byte);
            long_key = 1'b1;
          end
        end
      end
      OP_MSG: begin
        if (!msg_phase) close_key();
        sha_absorb(w.data_byte);
      end
      OP_FIN: begin
        if (!msg_phase) close_key();
        inner = sha_final();
        sha_start();
        for (int i = 0; i < 64; i++) sha_absorb(key_bytes[i] ^ OPAD_BYTE);
        for (int i = 0; i < 20; i++) sha_absorb(inner[159-8*i -: 8]);
        mac = sha_final();
        hmac_reset();
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  function automatic void queue_mac(input logic [159:0] mac);
    hs1e_out_t r;
    for (int i = 0; i < 5; i++) begin
      r.mac_word = mac[159-32*i -: 32];
      r.word_index = 3'(i);
      r.last_word = (i == 4);
      mac_q.push_back(r);
    end
  endfunction

  task automatic idle_gap();
    int r, g;
    r = $urandom_range(0, 99);
    if (r < 60) g = 0;
    else if (r < 92) g = $urandom_range(1, 3);
    else g = $urandom_range(10, 40);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // drive one word, wait for accept, update the predictor
  task automatic send_word(input hs1e_in_t w, input bit known, input logic [159:0] typed);
    logic [159:0] mac;
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    if (w.op != OP_NONE && !(w.op == OP_KEY && msg_phase)) sent_items++;
    if (hmac_step(w, mac)) queue_mac(known ? typed : mac);
    idle_gap();
  endtask

  task automatic send_rand(input logic [1:0] op);
    hs1e_in_t w;
    w.op = op;
    w.data_byte = 8'($urandom_range(0, 255));
    send_word(w, 1'b0, '0);
  endtask

  task automatic run_sequence();
    int klen, mlen, r;
    r = $urandom_range(0, 9);
    if (r < 6) klen = $urandom_range(0, 16);
    else if (r < 8) klen = 64;
    else klen = $urandom_range(65, 72);
    mlen = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 70) : $urandom_range(0, 30);
    for (int i = 0; i < klen; i++) begin
      if ($urandom_range(0, 29) == 0) send_rand(OP_NONE);
      send_rand(OP_KEY);
    end
    for (int i = 0; i < mlen; i++) begin
      r = $urandom_range(0, 29);
      if (r == 0) send_rand(OP_NONE);
      else if (r == 1) send_rand(OP_KEY);
      send_rand(OP_MSG);
    end
    send_rand(OP_FIN);
  endtask

  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      out_ready <= 1'b0;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(10, 40)) @(posedge clk);
      else repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    hs1e_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (mac_q.size() == 0) begin
        report("unexpected word", out_data.mac_word, 32'h0);
      end else begin
        want = mac_q.pop_front();
        if (out_data.mac_word !== want.mac_word)
          report("mac_word", out_data.mac_word, want.mac_word);
        if (out_data.word_index !== want.word_index)
          report("word_index", 32'(out_data.word_index), 32'(want.word_index));
        if (out_data.last_word !== want.last_word)
          report("last_word", 32'(out_data.last_word), 32'(want.last_word));
      end
    end
  end

  initial begin
    int seqs;
    errors = 0;
    sent_items = 0;
    seqs = 0;
    in_valid = 1'b0;
    in_data = '0;
    rst_n = 1'b0;
    hmac_reset();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[i]) send_word(dir_rows[i].word, dir_rows[i].known, dir_rows[i].mac);
    while (sent_items < 300) begin
      if (seqs == 2) begin
        in_valid <= 1'b0;
        while (mac_q.size() > 0) @(posedge clk);
      end
      run_sequence();
      seqs++;
    end
    in_valid <= 1'b0;
    while (mac_q.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("[hmac_sha1_engine] OK");
    end else begin
      $display("[hmac_sha1_engine] ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("[hmac_sha1_engine] ERROR");
    $finish;
  end

endmodule

### filelist.f
rtl/core/hs1e_pkg.sv
rtl/core/hs1e_core.sv
rtl/core/hmac_sha1_engine.sv
tb/sv/tb_hmac_sha1_engine.sv
